// ===== src/smtq_pkg.sv =====
package smtq_pkg;

  typedef enum logic [2:0] {
    OP_ADVANCE = 3'd0,
    OP_START   = 3'd1,
    OP_STOP    = 3'd2,
    OP_SETPER  = 3'd3,
    OP_QUERY   = 3'd4
  } op_e;

  localparam int unsigned SlotW = 4;
  localparam int unsigned CntW  = 32;
  localparam logic [CntW-1:0] Sat32 = 32'hffff_ffff;

  localparam logic RkExpire = 1'b0;
  localparam logic RkQuery  = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_REDUCE = 8'b0000_0010,
    S_FIND   = 8'b0000_0100,
    S_REMOVE = 8'b0000_1000,
    S_SCAN   = 8'b0001_0000,
    S_SHIFT  = 8'b0010_0000,
    S_HEAD   = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_e;

endpackage

// ===== src/sorted_multi_timer_queue.sv =====
// Start, or set period of a running timer, finds and removes it, ages the queue and re-inserts
// it; stop finds and removes it; query enters the emit state and its reply strobes in the next.
// Advance first checks the head, then per expiry removes the timer and ages the queue, and for
// a recurring timer re-inserts it, with one event strobe per expiry.
// Throughput is one request at a time: busy stays high until the request is done; all work
// walks the queue one entry a cycle. Reset (async, active low) empties the queue and clears
// flags, periods and elapsed.
module sorted_multi_timer_queue #(
  parameter int unsigned NUM_TIMERS = 13
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode_i,
  input  logic [3:0]  timer_id_i,
  input  logic [15:0] cycles_i,
  input  logic [30:0] period_us_i,
  input  logic        recurring_i,
  output logic        valid_o,
  output logic        result_kind_o,
  output logic [3:0]  timer_num_o,
  output logic        is_running_o,
  output logic [30:0] period_reply_o,
  output logic        last_o
);

  localparam int unsigned QW = $clog2(NUM_TIMERS + 1);
  localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CW = smtq_pkg::CntW;

  logic [CW-1:0] rem_q [NUM_TIMERS];
  logic [CW-1:0] per_q [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] run_q, rec_q, fired_q;
  logic [3:0]    ord_q [NUM_TIMERS];
  logic [QW-1:0] len_q;
  logic [CW-1:0] elap_q;

  smtq_pkg::state_e st_q;
  logic [QW-1:0] idx_q;
  logic [QW-1:0] pos_q;
  logic [3:0]    tid_q;
  logic [2:0]    op_q;
  logic          ins_q;

  logic          out_v_q, out_k_q, out_r_q, out_l_q;
  logic [3:0]    out_n_q;
  logic [30:0]   out_p_q;

  logic [IW-1:0] ix, ix1, tix, hix, ex;
  logic [CW-1:0] cur_rem, dif;
  logic          ge;
  logic          valid_id;

  assign busy = (st_q != smtq_pkg::S_IDLE);
  assign valid_id = ({1'b0, timer_id_i} < 5'(NUM_TIMERS));
  assign ix  = IW'(idx_q);
  assign ix1 = IW'(idx_q - QW'(1));
  assign tix = IW'(tid_q);
  assign hix = IW'(ord_q[0]);
  assign ex  = IW'(ord_q[ix]);
  // shared unit: the queued count at the walk pointer against elapsed or the new count
  assign cur_rem = rem_q[ex];
  assign dif = cur_rem - (ins_q ? rem_q[tix] : elap_q);
  assign ge  = (cur_rem >= elap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= smtq_pkg::S_IDLE;
      run_q   <= '0;
      rec_q   <= '0;
      fired_q <= '0;
      len_q   <= '0;
      elap_q  <= '0;
      idx_q   <= '0;
      out_v_q <= 1'b0;
      ins_q   <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) per_q[i] <= '0;
    end else begin
      // strobe the result prepared during the emit cycle
      out_v_q <= (st_q == smtq_pkg::S_EMIT);
      unique case (st_q)
        smtq_pkg::S_IDLE: begin
          if (start) begin
            op_q    <= opcode_i;
            tid_q   <= timer_id_i;
            idx_q   <= '0;
            fired_q <= '0;
            ins_q   <= 1'b0;
            case (opcode_i)
              smtq_pkg::OP_ADVANCE: begin
                elap_q <= (smtq_pkg::Sat32 - elap_q < {16'd0, cycles_i}) ? smtq_pkg::Sat32
                          : elap_q + {16'd0, cycles_i};
                st_q <= smtq_pkg::S_HEAD;
              end
              smtq_pkg::OP_START: if (valid_id) begin
                if (period_us_i != '0) per_q[IW'(timer_id_i)] <= {period_us_i, 1'b0};
                rec_q[IW'(timer_id_i)] <= recurring_i;
                st_q <= run_q[IW'(timer_id_i)] ? smtq_pkg::S_FIND : smtq_pkg::S_REDUCE;
              end
              smtq_pkg::OP_STOP: if (valid_id && run_q[IW'(timer_id_i)]) begin
                st_q <= smtq_pkg::S_FIND;
              end
              smtq_pkg::OP_SETPER: if (valid_id) begin
                per_q[IW'(timer_id_i)] <= {period_us_i, 1'b0};
                if (run_q[IW'(timer_id_i)]) st_q <= smtq_pkg::S_FIND;
              end
              smtq_pkg::OP_QUERY: begin
                out_k_q <= smtq_pkg::RkQuery;
                out_n_q <= timer_id_i;
                out_r_q <= valid_id & run_q[IW'(timer_id_i)];
                out_p_q <= valid_id ? per_q[IW'(timer_id_i)][31:1] : '0;
                out_l_q <= 1'b1;
                st_q    <= smtq_pkg::S_EMIT;
              end
              default: ;
            endcase
          end
        end
        // locate the addressed timer in the queue
        smtq_pkg::S_FIND: begin
          if (idx_q >= len_q) begin
            idx_q <= '0;
            st_q  <= (op_q == smtq_pkg::OP_STOP) ? smtq_pkg::S_IDLE : smtq_pkg::S_REDUCE;
            if (op_q == smtq_pkg::OP_STOP) run_q[tix] <= 1'b0;
          end else if (ord_q[ix] == tid_q) begin
            st_q <= smtq_pkg::S_REMOVE;
          end else idx_q <= idx_q + QW'(1);
        end
        // close the gap, one entry a cycle
        smtq_pkg::S_REMOVE: begin
          if (idx_q + QW'(1) >= len_q) begin
            len_q <= len_q - QW'(1);
            idx_q <= '0;
            if (op_q == smtq_pkg::OP_ADVANCE) st_q <= smtq_pkg::S_REDUCE;
            else if (op_q == smtq_pkg::OP_STOP) begin
              run_q[tix] <= 1'b0;
              st_q <= smtq_pkg::S_IDLE;
            end else st_q <= smtq_pkg::S_REDUCE;
          end else begin
            ord_q[ix] <= ord_q[IW'(idx_q + QW'(1))];
            idx_q <= idx_q + QW'(1);
          end
        end
        // subtract elapsed from each queued count, saturating
        smtq_pkg::S_REDUCE: begin
          if (idx_q >= len_q) begin
            elap_q <= '0;
            idx_q  <= '0;
            if (op_q == smtq_pkg::OP_ADVANCE) begin
              if (rec_q[tix]) begin
                rem_q[tix] <= per_q[tix];
                ins_q <= 1'b1;
                st_q  <= smtq_pkg::S_SCAN;
              end else begin
                run_q[tix] <= 1'b0;
                st_q <= smtq_pkg::S_EMIT;
                out_k_q <= smtq_pkg::RkExpire;
                out_n_q <= tid_q;
                out_r_q <= 1'b0;
                out_p_q <= per_q[tix][31:1];
              end
            end else begin
              rem_q[tix] <= per_q[tix];
              run_q[tix] <= 1'b1;
              ins_q <= 1'b1;
              st_q  <= smtq_pkg::S_SCAN;
            end
          end else begin
            rem_q[ex] <= ge ? dif : '0;
            idx_q <= idx_q + QW'(1);
          end
        end
        // find the insertion point: after every count not above the new one
        smtq_pkg::S_SCAN: begin
          if (idx_q < len_q && cur_rem <= rem_q[tix])
            idx_q <= idx_q + QW'(1);
          else begin
            idx_q <= len_q;
            st_q  <= smtq_pkg::S_SHIFT;
            pos_q <= idx_q;
          end
        end
        // open a gap from the tail, then place the timer
        smtq_pkg::S_SHIFT: begin
          if (idx_q > pos_q) begin
            ord_q[ix] <= ord_q[ix1];
            idx_q <= idx_q - QW'(1);
          end else begin
            ord_q[ix] <= tid_q;
            len_q <= len_q + QW'(1);
            ins_q <= 1'b0;
            idx_q <= '0;
            if (op_q == smtq_pkg::OP_ADVANCE) begin
              st_q <= smtq_pkg::S_EMIT;
              out_k_q <= smtq_pkg::RkExpire;
              out_n_q <= tid_q;
              out_r_q <= run_q[tix];
              out_p_q <= per_q[tix][31:1];
            end else st_q <= smtq_pkg::S_IDLE;
          end
        end
        // decide whether the head expires now
        smtq_pkg::S_HEAD: begin
          if (len_q != '0 && !fired_q[hix] && elap_q >= rem_q[hix]) begin
            fired_q[hix] <= 1'b1;
            tid_q <= ord_q[0];
            idx_q <= '0;
            st_q  <= smtq_pkg::S_REMOVE;
          end else begin
            st_q <= smtq_pkg::S_IDLE;
          end
        end
        // hold the prepared result and look for more on advance
        smtq_pkg::S_EMIT: begin
          if (op_q == smtq_pkg::OP_ADVANCE) begin
            if (len_q != '0 && !fired_q[hix] && elap_q >= rem_q[hix]) begin
              out_l_q <= 1'b0;
              fired_q[hix] <= 1'b1;
              tid_q <= ord_q[0];
              idx_q <= '0;
              st_q  <= smtq_pkg::S_REMOVE;
            end else begin
              out_l_q <= 1'b1;
              st_q <= smtq_pkg::S_IDLE;
            end
          end else st_q <= smtq_pkg::S_IDLE;
        end
        default: st_q <= smtq_pkg::S_IDLE;
      endcase
    end
  end

  assign valid_o        = out_v_q;
  assign result_kind_o  = out_k_q;
  assign timer_num_o    = out_n_q;
  assign is_running_o   = out_r_q;
  assign period_reply_o = out_p_q;
  assign last_o         = out_l_q;

endmodule

// ===== src/smtq_checker.sv =====
module smtq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       busy,
  input logic       valid_o,
  input logic       result_kind_o,
  input logic       last_o
);

  // a result only comes while a request is in work
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy)) else $error("result without request");

  // a query reply is always the final result
  a_q_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_kind_o |-> last_o) else $error("query reply not last");

  // more results to come keep the block busy
  a_more: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy) else $error("idle before last result");

  // the final result ends the request
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |=> !valid_o) else $error("result after last");

endmodule

bind sorted_multi_timer_queue smtq_checker u_smtq_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .busy(busy),
  .valid_o(valid_o), .result_kind_o(result_kind_o), .last_o(last_o)
);

// ===== dv/sorted_multi_timer_queue_test.sv =====
module sorted_multi_timer_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NT = 13;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic        kind;
    logic [3:0]  num;
    logic        running;
    logic [30:0] period;
    logic        last;
  } timer_reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  opcode_i;
  logic [3:0]  timer_id_i;
  logic [15:0] cycles_i;
  logic [30:0] period_us_i;
  logic        recurring_i;
  logic        valid_o;
  logic        result_kind_o;
  logic [3:0]  timer_num_o;
  logic        is_running_o;
  logic [30:0] period_reply_o;
  logic        last_o;

  sorted_multi_timer_queue #(.NUM_TIMERS(NT)) u_top (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .timer_id_i, .cycles_i,
    .period_us_i, .recurring_i, .valid_o, .result_kind_o, .timer_num_o,
    .is_running_o, .period_reply_o, .last_o
  );

  // Mirror of the timer bank
  logic [31:0] remain_q [16];
  logic [31:0] period_q [16];
  logic        run_q [16];
  logic        recur_q [16];
  logic [3:0]  order_q [16];
  int unsigned qlen_q;
  logic [31:0] elapsed_q;

  timer_reply_t replies_q[$];
  int unsigned  mismatches;
  int unsigned  cycle_cnt;
  bit           idle_on;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shrink queued counts by elapsed time
  function automatic void shrink_counts();
    logic [3:0] t;
    for (int i = 0; i < qlen_q; i++) begin
      t = order_q[i];
      remain_q[t] = (remain_q[t] > elapsed_q) ? remain_q[t] - elapsed_q : 32'd0;
    end
    elapsed_q = 32'd0;
  endfunction

  function automatic void drop_at(int unsigned pos);
    if (pos >= qlen_q) return;
    for (int unsigned i = pos; i + 1 < qlen_q; i++) order_q[i] = order_q[i+1];
    qlen_q--;
  endfunction

  function automatic void place_sorted(logic [3:0] t);
    int unsigned pos;
    pos = 0;
    if (qlen_q >= 16) return;
    while (pos < qlen_q && remain_q[order_q[pos]] <= remain_q[t]) pos++;
    for (int unsigned i = qlen_q; i > pos; i--) order_q[i] = order_q[i-1];
    order_q[pos] = t;
    qlen_q++;
  endfunction

  function automatic void unlink(logic [3:0] t);
    for (int unsigned i = 0; i < qlen_q; i++) begin
      if (order_q[i] == t) begin
        drop_at(i);
        return;
      end
    end
  endfunction

  function automatic void arm_timer(logic [3:0] t);
    if (run_q[t]) unlink(t);
    shrink_counts();
    remain_q[t] = period_q[t];
    run_q[t] = 1'b1;
    place_sorted(t);
  endfunction

  // Compute the replies a request causes and queue them
  function automatic void predict_replies(smtq_pkg::op_e op, logic [3:0] id, logic [15:0] cyc,
                                          logic [30:0] per, logic rec);
    logic [15:0]  fired;
    logic [3:0]   h;
    timer_reply_t r;
    int           n;
    bit           ok;
    fired = '0;
    n = 0;
    ok = id < NT;
    case (op)
      smtq_pkg::OP_ADVANCE: begin
        elapsed_q = (smtq_pkg::Sat32 - elapsed_q < cyc) ? smtq_pkg::Sat32 : elapsed_q + cyc;
        while (qlen_q > 0) begin
          h = order_q[0];
          if (fired[h] || elapsed_q < remain_q[h]) break;
          fired[h] = 1'b1;
          if (!recur_q[h]) run_q[h] = 1'b0;
          drop_at(0);
          shrink_counts();
          if (recur_q[h]) begin
            remain_q[h] = period_q[h];
            place_sorted(h);
          end
          r = '{smtq_pkg::RkExpire, h, run_q[h], period_q[h][31:1], 1'b0};
          replies_q.push_back(r);
          n++;
        end
        if (n > 0) replies_q[$].last = 1'b1;
      end
      smtq_pkg::OP_START: if (ok) begin
        if (per != 0) period_q[id] = {per, 1'b0};
        recur_q[id] = rec;
        arm_timer(id);
      end
      smtq_pkg::OP_STOP: if (ok && run_q[id]) begin
        unlink(id);
        run_q[id] = 1'b0;
      end
      smtq_pkg::OP_SETPER: if (ok) begin
        period_q[id] = {per, 1'b0};
        if (run_q[id]) arm_timer(id);
      end
      smtq_pkg::OP_QUERY: begin
        if (ok) r = '{smtq_pkg::RkQuery, id, run_q[id], period_q[id][31:1], 1'b1};
        else r = '{smtq_pkg::RkQuery, id, 1'b0, 31'd0, 1'b1};
        replies_q.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Check each strobed reply against the oldest prediction
  always @(posedge clk_i) begin
    timer_reply_t got;
    timer_reply_t want;
    got = '{result_kind_o, timer_num_o, is_running_o, period_reply_o, last_o};
    if (rst_ni && valid_o) begin
      if (replies_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reply %p", got);
      end else begin
        want = replies_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("reply mismatch: exp %p got %p", want, got);
        end
      end
    end
  end

  // Run guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_request(smtq_pkg::op_e op, logic [3:0] id, logic [15:0] cyc,
                              logic [30:0] per, logic rec);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= op;
    timer_id_i <= id;
    cycles_i <= cyc;
    period_us_i <= per;
    recurring_i <= rec;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_replies(op, id, cyc, per, rec);
    start <= 1'b0;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain_replies();
    while (replies_q.size() != 0) @(posedge clk_i);
    repeat (4 * NT + 10) @(posedge clk_i);
  endtask

  // Extremes, each opcode, invalid ids, zero-period recurring timer
  task automatic test_directed();
    send_request(smtq_pkg::OP_QUERY, 4'd0, 16'd0, 31'd0, 1'b0);
    send_request(smtq_pkg::OP_QUERY, 4'd15, 16'd0, 31'd0, 1'b0);
    send_request(smtq_pkg::OP_START, 4'd0, 16'd0, 31'd3, 1'b0);
    send_request(smtq_pkg::OP_START, 4'd1, 16'd0, 31'd3, 1'b1);
    send_request(smtq_pkg::OP_START, 4'd2, 16'd0, 31'h7fffffff, 1'b1);
    send_request(smtq_pkg::OP_START, 4'd3, 16'd0, 31'd0, 1'b1);
    send_request(smtq_pkg::OP_START, 4'd14, 16'd0, 31'd5, 1'b1);
    send_request(smtq_pkg::OP_QUERY, 4'd2, 16'd0, 31'd0, 1'b0);
    send_request(smtq_pkg::OP_ADVANCE, 4'd0, 16'd6, 31'd0, 1'b0);
    send_request(smtq_pkg::OP_ADVANCE, 4'd0, 16'd0, 31'd0, 1'b0);
    send_request(smtq_pkg::OP_SETPER, 4'd1, 16'd0, 31'd1, 1'b0);
    send_request(smtq_pkg::OP_SETPER, 4'd5, 16'd0, 31'd9, 1'b0);
    send_request(smtq_pkg::OP_STOP, 4'd5, 16'd0, 31'd0, 1'b0);
    send_request(smtq_pkg::OP_STOP, 4'd3, 16'd0, 31'd0, 1'b0);
    send_request(smtq_pkg::OP_STOP, 4'd15, 16'd0, 31'd0, 1'b0);
    send_request(smtq_pkg::op_e'(3'd5), 4'd1, 16'd1, 31'd1, 1'b1);
    send_request(smtq_pkg::op_e'(3'd7), 4'd1, 16'd1, 31'd1, 1'b1);
    send_request(smtq_pkg::OP_ADVANCE, 4'd0, 16'hffff, 31'd0, 1'b0);
    send_request(smtq_pkg::OP_QUERY, 4'd12, 16'd0, 31'd0, 1'b0);
    drain_replies();
  endtask

  // Mostly short periods so advances expire timers often
  task automatic test_random(int count, bit gaps);
    logic [2:0]  op;
    logic [30:0] per;
    int          pick;
    idle_on = gaps;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      op = (pick < 4) ? 3'd0 : (pick < 6) ? 3'd1 : (pick < 7) ? 3'd2 :
           (pick < 8) ? 3'd3 : (pick < 9) ? 3'd4 : 3'($urandom_range(5, 7));
      per = ($urandom_range(0, 15) == 0) ? 31'($urandom) : 31'($urandom_range(0, 200));
      send_request(smtq_pkg::op_e'(op), 4'($urandom_range(0, 15)),
                   16'($urandom_range(0, 400)) ^
                   (($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'd0),
                   per, 1'($urandom));
      if (i == count / 2) drain_replies();
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    opcode_i = '0;
    timer_id_i = '0;
    cycles_i = '0;
    period_us_i = '0;
    recurring_i = 1'b0;
    mismatches = 0;
    cycle_cnt = 0;
    idle_on = 1'b1;
    for (int i = 0; i < 16; i++) begin
      remain_q[i] = '0;
      period_q[i] = '0;
      run_q[i] = 1'b0;
      recur_q[i] = 1'b0;
      order_q[i] = '0;
    end
    qlen_q = 0;
    elapsed_q = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(80, 1'b1);
    test_random(30, 1'b0);
    drain_replies();
    if (mismatches == 0 && replies_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
